// ----- sv/vng_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vng_pkg
// Shared constants and types of the value noise pixel generator.
// ----------------------------------------------------------------------------
package vng_pkg;

    localparam int POS_W      = 12;               // pixel coordinate width
    localparam int FRAC_W     = 16;               // Q0.16 fraction
    localparam int DVD_W      = POS_W + FRAC_W;   // dividend of the long division
    localparam int BS_W       = 9;                // block size width
    localparam int DIV_STEPS  = 4;                // quotient bits per divider stage
    localparam int DIV_STAGES = DVD_W / DIV_STEPS;

    typedef enum logic [1:0] {
        CFG_BLOCK_SIZE   = 2'd0,
        CFG_IMAGE_WIDTH  = 2'd1,
        CFG_IMAGE_HEIGHT = 2'd2
    } t_cfg_reg;

endpackage

// ----- sv/vng_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vng_div
// Pipelined restoring divider, DIV_STEPS quotient bits per stage.
// ----------------------------------------------------------------------------
module vng_div import vng_pkg::*; (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic [DVD_W-1:0]    i_dividend,
    input  logic [BS_W-1:0]     i_divisor,
    output logic [DVD_W-1:0]    o_quotient
);

    typedef struct packed {
        logic [BS_W-1:0]  rem;
        logic [DVD_W-1:0] dvd;
        logic [DVD_W-1:0] quo;
    } t_div_st;

    function automatic t_div_st div_steps(t_div_st st_in, logic [BS_W-1:0] d);
        t_div_st       st;
        logic [BS_W:0] r2;
        st = st_in;
        for (int i = 0; i < DIV_STEPS; i++) begin
            r2     = {st.rem, st.dvd[DVD_W-1]};
            st.dvd = {st.dvd[DVD_W-2:0], 1'b0};
            if (r2 >= {1'b0, d}) begin
                st.rem = BS_W'(r2 - {1'b0, d});
                st.quo = {st.quo[DVD_W-2:0], 1'b1};
            end else begin
                st.rem = r2[BS_W-1:0];
                st.quo = {st.quo[DVD_W-2:0], 1'b0};
            end
        end
        return st;
    endfunction

    t_div_st r_st [DIV_STAGES];
    t_div_st n_st [DIV_STAGES];

    always_comb begin
        n_st[0] = div_steps('{rem: '0, dvd: i_dividend, quo: '0}, i_divisor);
        for (int k = 1; k < DIV_STAGES; k++) begin
            n_st[k] = div_steps(r_st[k-1], i_divisor);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_quotient = r_st[DIV_STAGES-1].quo;

endmodule

// ----- sv/value_noise_pixel_generator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_noise_pixel_generator_core
// Smoothstep value noise with bilinear blend over a software-written lattice.
// ----------------------------------------------------------------------------
// Takes one word per clock and gives one pixel per clock while the output is
// not stalled. A read word passes through one input stage, seven stages of
// the long division of the coordinate by the block size (four quotient bits
// each), then index clamp and t*t, smoothstep and lattice read, horizontal
// blend and vertical blend before it leaves the output. A write word
// updates the lattice at the same point of the pipeline where reads look it
// up, so reads and writes keep their order; it gives no output word.
module value_noise_pixel_generator_core import vng_pkg::*; #(
    parameter int MAX_LATTICE_COLS = 64,
    parameter int MAX_LATTICE_ROWS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // lattice_col[5:0], lattice_row[11:6], lattice_value[19:12],
    // pixel_x[31:20], pixel_y[43:32], zero[47:44]
    input  logic [47:0] i_s_axis_tdata,
    // cmd[0]
    input  logic        i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // pixel_value[7:0]
    output logic [7:0]  o_m_axis_tdata,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [12:0] i_cfg_wdata
);

    localparam int COL_W     = $clog2(MAX_LATTICE_COLS);
    localparam int ROW_W     = $clog2(MAX_LATTICE_ROWS);
    localparam int MEM_DEPTH = 1 << (COL_W + ROW_W);
    localparam int NA        = DIV_STAGES + 1;

    function automatic logic [7:0] blend(logic [7:0] a, logic [7:0] b, logic [15:0] s);
        logic [16:0] sc;
        logic [24:0] acc;
        sc  = 17'h10000 - {1'b0, s};
        acc = 25'(a) * 25'(sc) + 25'(b) * 25'(s);
        return acc[23:16];
    endfunction

    // {i0, i1} from quotient of the position and of the last pixel
    function automatic logic [2*POS_W-1:0] axis_idx(logic [POS_W-1:0] q,
                                                     logic [POS_W-1:0] ql,
                                                     logic [POS_W-1:0] maxm1);
        logic [POS_W-1:0] last;
        logic [POS_W-1:0] i0;
        logic [POS_W-1:0] i1;
        last = (ql > maxm1) ? maxm1 : ql;
        i0   = (q > last) ? last : q;
        i1   = (i0 == last) ? last : POS_W'(i0 + 1'b1);
        return {i0, i1};
    endfunction

    // configuration, stored already clamped
    logic [BS_W-1:0]  r_bs;
    logic [POS_W-1:0] r_wm1;
    logic [POS_W-1:0] r_hm1;
    logic [POS_W-1:0] n_size_m1;

    always_comb begin
        if (i_cfg_wdata == 13'd0) begin
            n_size_m1 = '0;
        end else if (i_cfg_wdata > 13'd4096) begin
            n_size_m1 = '1;
        end else begin
            n_size_m1 = POS_W'(i_cfg_wdata - 13'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bs  <= BS_W'(16);
            r_wm1 <= POS_W'(255);
            r_hm1 <= POS_W'(255);
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_BLOCK_SIZE: begin
                    if (i_cfg_wdata[8:0] == 9'd0) begin
                        r_bs <= BS_W'(1);
                    end else if (i_cfg_wdata[8:0] > 9'd256) begin
                        r_bs <= BS_W'(256);
                    end else begin
                        r_bs <= i_cfg_wdata[8:0];
                    end
                end
                CFG_IMAGE_WIDTH:  r_wm1 <= n_size_m1;
                CFG_IMAGE_HEIGHT: r_hm1 <= n_size_m1;
                default: ;
            endcase
        end
    end

    logic en;
    assign en              = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = en;

    // input stage and sideband that follows the divider
    logic             r_vld  [NA];
    logic             r_cmd  [NA];
    logic [5:0]       r_wcol [NA];
    logic [5:0]       r_wrow [NA];
    logic [7:0]       r_wval [NA];
    logic [POS_W-1:0] r_px;
    logic [POS_W-1:0] r_py;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < NA; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (en) begin
            r_vld[0] <= i_s_axis_tvalid;
            for (int k = 1; k < NA; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cmd[0]  <= i_s_axis_tuser;
            r_wcol[0] <= i_s_axis_tdata[5:0];
            r_wrow[0] <= i_s_axis_tdata[11:6];
            r_wval[0] <= i_s_axis_tdata[19:12];
            r_px <= (i_s_axis_tdata[31:20] > r_wm1) ? r_wm1 : i_s_axis_tdata[31:20];
            r_py <= (i_s_axis_tdata[43:32] > r_hm1) ? r_hm1 : i_s_axis_tdata[43:32];
            for (int k = 1; k < NA; k++) begin
                r_cmd[k]  <= r_cmd[k-1];
                r_wcol[k] <= r_wcol[k-1];
                r_wrow[k] <= r_wrow[k-1];
                r_wval[k] <= r_wval[k-1];
            end
        end
    end

    // quotient high part is the block index, low part the Q0.16 fraction
    logic [DVD_W-1:0] qx, qy, qlx, qly;

    vng_div u_div_x (
        .i_clk(i_clk), .i_en(en), .i_dividend({r_px, FRAC_W'(0)}),
        .i_divisor(r_bs), .o_quotient(qx)
    );
    vng_div u_div_y (
        .i_clk(i_clk), .i_en(en), .i_dividend({r_py, FRAC_W'(0)}),
        .i_divisor(r_bs), .o_quotient(qy)
    );
    vng_div u_div_lx (
        .i_clk(i_clk), .i_en(en), .i_dividend({r_wm1, FRAC_W'(0)}),
        .i_divisor(r_bs), .o_quotient(qlx)
    );
    vng_div u_div_ly (
        .i_clk(i_clk), .i_en(en), .i_dividend({r_hm1, FRAC_W'(0)}),
        .i_divisor(r_bs), .o_quotient(qly)
    );

    // stage 1: index clamp, t*t
    logic [2*POS_W-1:0] n_xi, n_yi;
    assign n_xi = axis_idx(qx[DVD_W-1:FRAC_W], qlx[DVD_W-1:FRAC_W],
                           POS_W'(MAX_LATTICE_COLS - 1));
    assign n_yi = axis_idx(qy[DVD_W-1:FRAC_W], qly[DVD_W-1:FRAC_W],
                           POS_W'(MAX_LATTICE_ROWS - 1));

    logic              r_vld1, r_cmd1;
    logic [5:0]        r_wcol1, r_wrow1;
    logic [7:0]        r_wval1;
    logic [COL_W-1:0]  r_x0, r_x1;
    logic [ROW_W-1:0]  r_y0, r_y1;
    logic [FRAC_W-1:0] r_tx, r_ty, r_ux, r_uy;
    logic [2*FRAC_W-1:0] n_ttx, n_tty;

    assign n_ttx = qx[FRAC_W-1:0] * qx[FRAC_W-1:0];
    assign n_tty = qy[FRAC_W-1:0] * qy[FRAC_W-1:0];

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cmd1  <= r_cmd[NA-1];
            r_wcol1 <= r_wcol[NA-1];
            r_wrow1 <= r_wrow[NA-1];
            r_wval1 <= r_wval[NA-1];
            r_x0    <= n_xi[POS_W+COL_W-1:POS_W];
            r_x1    <= n_xi[COL_W-1:0];
            r_y0    <= n_yi[POS_W+ROW_W-1:POS_W];
            r_y1    <= n_yi[ROW_W-1:0];
            r_tx    <= qx[FRAC_W-1:0];
            r_ty    <= qy[FRAC_W-1:0];
            r_ux    <= n_ttx[2*FRAC_W-1:FRAC_W];
            r_uy    <= n_tty[2*FRAC_W-1:FRAC_W];
        end
    end

    // stage 2: smoothstep, lattice read and write
    function automatic logic [FRAC_W-1:0] smooth(logic [FRAC_W-1:0] t, logic [FRAC_W-1:0] u);
        logic [FRAC_W+1:0]   k;
        logic [2*FRAC_W+1:0] p;
        k = 18'(196608) - {1'b0, t, 1'b0};
        p = 34'(u) * 34'(k);
        return (p[2*FRAC_W+1:FRAC_W] > 18'hFFFF) ? '1 : p[2*FRAC_W-1:FRAC_W];
    endfunction

    logic [7:0] mem_00 [MEM_DEPTH];
    logic [7:0] mem_10 [MEM_DEPTH];
    logic [7:0] mem_01 [MEM_DEPTH];
    logic [7:0] mem_11 [MEM_DEPTH];

    logic       mem_we;
    logic [8:0] wcol9, wrow9;
    logic [COL_W+ROW_W-1:0] waddr;

    assign wcol9  = 9'(r_wcol1);
    assign wrow9  = 9'(r_wrow1);
    assign waddr  = {wrow9[ROW_W-1:0], wcol9[COL_W-1:0]};
    assign mem_we = en && r_vld1 && !r_cmd1 &&
                    (wcol9 < 9'(MAX_LATTICE_COLS)) && (wrow9 < 9'(MAX_LATTICE_ROWS));

    logic              r_vld2;
    logic [FRAC_W-1:0] r_sx, r_sy;
    logic [7:0]        r_v00, r_v10, r_v01, r_v11;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem_00[waddr] <= r_wval1;
            mem_10[waddr] <= r_wval1;
            mem_01[waddr] <= r_wval1;
            mem_11[waddr] <= r_wval1;
        end
        if (en) begin
            r_v00 <= mem_00[{r_y0, r_x0}];
            r_v10 <= mem_10[{r_y0, r_x1}];
            r_v01 <= mem_01[{r_y1, r_x0}];
            r_v11 <= mem_11[{r_y1, r_x1}];
            r_sx  <= smooth(r_tx, r_ux);
            r_sy  <= smooth(r_ty, r_uy);
        end
    end

    // stage 3: horizontal blend; stage 4: vertical blend
    logic              r_vld3, r_vld4;
    logic [7:0]        r_top, r_bot, r_pix;
    logic [FRAC_W-1:0] r_sy3;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_top <= blend(r_v00, r_v10, r_sx);
            r_bot <= blend(r_v01, r_v11, r_sx);
            r_sy3 <= r_sy;
            r_pix <= blend(r_top, r_bot, r_sy3);
        end
    end

    // write words drop out after the lattice stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld1 <= 1'b0;
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
            r_vld4 <= 1'b0;
        end else if (en) begin
            r_vld1 <= r_vld[NA-1];
            r_vld2 <= r_vld1 && r_cmd1;
            r_vld3 <= r_vld2;
            r_vld4 <= r_vld3;
        end
    end

    assign o_m_axis_tvalid = r_vld4;
    assign o_m_axis_tdata  = r_pix;

    a_accept_enters : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_vld[0])
        else $error("accepted word missing from input stage");

    a_stall_holds : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> ($stable(r_vld1) && $stable(r_vld2) && $stable(r_vld3) && $stable(r_vld4)))
        else $error("pipeline moved during stall");

    a_x_neighbor : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld1 && r_cmd1) |-> (r_x1 == r_x0 || r_x1 == COL_W'(r_x0 + 1'b1)))
        else $error("column neighbor out of step");

    a_x_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld1 && r_cmd1) |->
        (32'(r_x1) < MAX_LATTICE_COLS && 32'(r_y1) < MAX_LATTICE_ROWS))
        else $error("lattice index past store");

endmodule

// ----- tb/tb_value_noise_pixel_generator_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_value_noise_pixel_generator_core
// Self-checking bench: lattice writes and pixel reads are streamed in under
// several block and image sizes; each pixel word is checked against a model.
// ----------------------------------------------------------------------------
module tb_value_noise_pixel_generator_core;
    import vng_pkg::*;

    localparam bit CMD_WRITE = 1'b0;
    localparam bit CMD_READ  = 1'b1;
    localparam int COLS      = 64;
    localparam int ROWS      = 64;
    localparam int FILL      = 24;
    localparam int IDLE_MAX  = 20000;

    // ------------------------------------------------------------------------
    class pixel_scoreboard;
        bit [7:0]  lattice [COLS*ROWS];
        bit [8:0]  blk;
        bit [12:0] width;
        bit [12:0] height;
        bit [7:0]  pixels_due[$];
        int        mismatches;
        int        checked;

        function void init();
            blk = 16; width = 256; height = 256;
        endfunction

        function bit [15:0] smooth(int unsigned off, int unsigned bs);
            longint unsigned t, u, k, s;
            t = (longint'(off) << 16) / bs;
            if (t > 65535) t = 65535;
            u = (t * t) >> 16;
            k = 3 * 65536 - 2 * t;
            s = (u * k) >> 16;
            if (s > 65535) s = 65535;
            return s[15:0];
        endfunction

        function bit [7:0] mix(bit [7:0] a, bit [7:0] b, bit [15:0] s);
            longint unsigned r;
            r = (longint'(a) * (65536 - s) + longint'(b) * s) >> 16;
            return r[7:0];
        endfunction

        function void resolve(int unsigned pos, int unsigned sz, int unsigned bs,
                              int unsigned pts, output int unsigned i0,
                              output int unsigned i1, output bit [15:0] fr);
            int unsigned last;
            if (pos > sz - 1) pos = sz - 1;
            last = (sz + bs - 1) / bs - 1;
            if (last > pts - 1) last = pts - 1;
            i0 = pos / bs;
            fr = smooth(pos % bs, bs);
            if (i0 > last) i0 = last;
            i1 = (i0 + 1 > last) ? last : i0 + 1;
        endfunction

        function void config_reg(t_cfg_reg r, bit [12:0] v);
            case (r)
                CFG_BLOCK_SIZE:   blk = v[8:0];
                CFG_IMAGE_WIDTH:  width = v;
                CFG_IMAGE_HEIGHT: height = v;
                default: ;
            endcase
        endfunction

        function void note_word(bit cmd, bit [47:0] d);
            int unsigned bs, w, h, x0, x1, y0, y1;
            bit [15:0] sx, sy;
            bit [7:0] top, bot;
            if (cmd == CMD_WRITE) begin
                lattice[d[11:6] * COLS + d[5:0]] = d[19:12];
                return;
            end
            bs = (blk == 0) ? 1 : (blk > 256 ? 256 : blk);
            w = (width == 0) ? 1 : (width > 4096 ? 4096 : width);
            h = (height == 0) ? 1 : (height > 4096 ? 4096 : height);
            resolve(d[31:20], w, bs, COLS, x0, x1, sx);
            resolve(d[43:32], h, bs, ROWS, y0, y1, sy);
            top = mix(lattice[y0*COLS+x0], lattice[y0*COLS+x1], sx);
            bot = mix(lattice[y1*COLS+x0], lattice[y1*COLS+x1], sx);
            pixels_due.push_back(mix(top, bot, sy));
        endfunction

        function void check_pixel(bit [7:0] got);
            bit [7:0] exp_px;
            checked++;
            if (pixels_due.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected pixel word %0d", got);
                return;
            end
            exp_px = pixels_due.pop_front();
            if (exp_px !== got) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("pixel mismatch: expected %0d got %0d", exp_px, got);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [47:0] s_data = '0;
    logic        s_user = 1'b0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_data;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [12:0] cfg_wdata = '0;

    pixel_scoreboard sb;
    int  idle_cycles;
    int  accepted;
    bit  timed_out;
    bit  rx_steady;

    value_noise_pixel_generator_core dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .i_cfg_we        (cfg_we),
        .i_cfg_addr      (cfg_addr),
        .i_cfg_wdata     (cfg_wdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // result side: sample at rising edge, throttle at falling edge
    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready) sb.check_pixel(m_data);
        if (i_rst_n && ((s_valid && s_ready) || (m_valid && m_ready)))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    always @(negedge i_clk)
        m_ready <= rx_steady ? 1'b1 : ($urandom_range(99) >= 35);

    always @(posedge i_clk) begin
        if (idle_cycles >= IDLE_MAX && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog: no traffic for %0d cycles", IDLE_MAX);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // valid stays up after a word so back-to-back words need no gap;
    // idle cycles and drain() drop it
    task automatic send_word(bit cmd, bit [47:0] d, bit gaps);
        int unsigned idle_n;
        idle_n = 0;
        while (gaps && $urandom_range(99) < 35) idle_n++;
        if (idle_n != 0) begin
            s_valid <= 1'b0;
            repeat (idle_n) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_user  <= cmd;
        s_data  <= d;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        sb.note_word(cmd, d);
        accepted++;
        @(negedge i_clk);
    endtask

    task automatic write_lattice(int c, int r, bit [7:0] v, bit gaps);
        bit [47:0] d;
        d = {4'd0, 12'($urandom), 12'($urandom), v, 6'(r), 6'(c)};
        send_word(CMD_WRITE, d, gaps);
    endtask

    task automatic read_pixel(int x, int y, bit gaps);
        bit [47:0] d;
        d = {4'd0, 12'(y), 12'(x), 8'($urandom), 6'($urandom), 6'($urandom)};
        send_word(CMD_READ, d, gaps);
    endtask

    // sender idles until every pixel is back, then lets the pipeline empty
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pixels_due.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic set_reg(t_cfg_reg r, bit [12:0] v);
        drain();
        cfg_we <= 1'b1;
        cfg_addr <= r;
        cfg_wdata <= v;
        sb.config_reg(r, v);
        @(negedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic random_phase(int n);
        int i;
        for (i = 0; i < n; i++) begin
            if ($urandom_range(99) < 20)
                write_lattice($urandom_range(63), $urandom_range(63), 8'($urandom), 1);
            else if ($urandom_range(99) < 15)
                read_pixel($urandom_range(4095), $urandom_range(4095), 1);
            else
                read_pixel($urandom_range(sb.width), $urandom_range(sb.height), 1);
        end
    endtask

    initial begin
        int r, c;
        sb = new();
        sb.init();
        idle_cycles = 0;
        rx_steady = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // fill the lattice corner every config below reaches, plus the far corner
        rx_steady = 1'b1;
        for (r = 0; r < FILL; r++)
            for (c = 0; c < FILL; c++)
                write_lattice(c, r, 8'($urandom), 0);
        write_lattice(0, 0, 8'h00, 0);
        write_lattice(1, 0, 8'hff, 0);
        write_lattice(0, 1, 8'hff, 0);
        write_lattice(1, 1, 8'h00, 0);
        write_lattice(63, 63, 8'hff, 0);
        write_lattice(63, 62, 8'h80, 0);

        // directed reads under reset config
        read_pixel(0, 0, 0);
        read_pixel(8, 8, 0);
        read_pixel(15, 15, 0);
        read_pixel(255, 255, 0);
        read_pixel(4095, 4095, 0);
        read_pixel(4095, 0, 0);
        read_pixel(0, 4095, 0);
        read_pixel(12'haaa, 12'h555, 0);
        read_pixel(12'h555, 12'haaa, 0);

        // extremes: block size 1 and max, big image (lattice clamp)
        set_reg(CFG_BLOCK_SIZE, 13'd1);
        read_pixel(70, 70, 0);
        read_pixel(63, 62, 0);
        set_reg(CFG_BLOCK_SIZE, 13'd256);
        set_reg(CFG_IMAGE_WIDTH, 13'd4096);
        set_reg(CFG_IMAGE_HEIGHT, 13'd4096);
        read_pixel(255, 128, 0);
        read_pixel(4095, 4095, 0);
        set_reg(CFG_BLOCK_SIZE, 13'd3);
        set_reg(CFG_IMAGE_WIDTH, 13'd1);
        set_reg(CFG_IMAGE_HEIGHT, 13'd1);
        read_pixel(5, 9, 0);

        // random phases with idling on both sides
        rx_steady = 1'b0;
        set_reg(CFG_BLOCK_SIZE, 13'd16);
        set_reg(CFG_IMAGE_WIDTH, 13'd256);
        set_reg(CFG_IMAGE_HEIGHT, 13'd256);
        random_phase(200);
        drain();                            // sender waits for all results
        set_reg(CFG_BLOCK_SIZE, 13'd13);
        set_reg(CFG_IMAGE_WIDTH, 13'd300);
        set_reg(CFG_IMAGE_HEIGHT, 13'd100);
        random_phase(200);
        set_reg(CFG_BLOCK_SIZE, 13'd1);
        set_reg(CFG_IMAGE_WIDTH, 13'd20);
        set_reg(CFG_IMAGE_HEIGHT, 13'd24);
        random_phase(200);
        set_reg(CFG_BLOCK_SIZE, 13'd256);
        set_reg(CFG_IMAGE_WIDTH, 13'd4096);
        set_reg(CFG_IMAGE_HEIGHT, 13'd4096);
        random_phase(200);
        set_reg(CFG_BLOCK_SIZE, 13'd100);
        set_reg(CFG_IMAGE_WIDTH, 13'd2000);
        set_reg(CFG_IMAGE_HEIGHT, 13'd777);
        rx_steady = 1'b1;                   // long stretch, no stalls
        for (r = 0; r < 200; r++)
            read_pixel($urandom_range(2047), $urandom_range(1023), 0);
        rx_steady = 1'b0;
        random_phase(200);

        drain();
        $display("ran %0d input words, checked %0d pixels over several block sizes",
                 accepted, sb.checked);
        $display("block sizes 1..256, image sizes 1..4096, lattice writes and edge clamps");
        if (sb.mismatches == 0 && sb.pixels_due.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ----- value_noise_pixel_generator_core.f -----
sv/vng_pkg.sv
sv/vng_div.sv
sv/value_noise_pixel_generator_core.sv
tb/tb_value_noise_pixel_generator_core.sv
